// ===== hw/rtl/u8xd_pkg.sv =====
package u8xd_pkg;

  // Field widths of the input and result words.
  localparam int unsigned UnitW     = 8;
  localparam int unsigned CodeW     = 32;
  localparam int unsigned CountW    = 3;
  localparam int unsigned AccW      = 31;
  localparam int unsigned PayloadW  = 6;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 40;

  typedef logic [UnitW-1:0]  unit_t;
  typedef logic [CodeW-1:0]  code_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [AccW-1:0]   acc_t;

  // Bytes that stand alone with a special mapping.
  localparam unit_t ByteFe    = 8'hFE;
  localparam unit_t ByteFf    = 8'hFF;
  localparam code_t CodeFe    = 32'hFFFF_FFFE;
  localparam code_t CodeFf    = 32'hFFFF_FFFF;

  localparam count_t LenSingle = 3'd1;
  localparam count_t LenMax    = 3'd6;

  // Sequence length opened by a byte seen while idle; one for anything else.
  function automatic count_t lead_length(unit_t b);
    count_t len;
    case (b) inside
      [8'hC0:8'hDF]: len = 3'd2;
      [8'hE0:8'hEF]: len = 3'd3;
      [8'hF0:8'hF7]: len = 3'd4;
      [8'hF8:8'hFB]: len = 3'd5;
      [8'hFC:8'hFD]: len = 3'd6;
      default:       len = LenSingle;
    endcase
    return len;
  endfunction

  // Payload bits that a lead byte carries, by sequence length.
  function automatic acc_t lead_payload(unit_t b, count_t len);
    acc_t acc;
    case (len)
      3'd2:    acc = {26'd0, b[4:0]};
      3'd3:    acc = {27'd0, b[3:0]};
      3'd4:    acc = {28'd0, b[2:0]};
      3'd5:    acc = {29'd0, b[1:0]};
      3'd6:    acc = {30'd0, b[0]};
      default: acc = '0;
    endcase
    return acc;
  endfunction

endpackage

// ===== hw/rtl/utf8_extended_stream_decoder_core.sv =====
// Decoder for the original UTF-8 form with sequences of up to six bytes.
// A code point is presented in the cycle after its last byte is accepted.
// One byte per cycle unless a held output word is not being taken.
// The output register frees itself in the cycle its word is taken.
// Reset (rst_ni low, asynchronous) clears the sequence state and the output valid.
module utf8_extended_stream_decoder_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // Fields from bit 0: unit_byte[7:0].
  input  logic [u8xd_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // Fields from bit 0: code_point[31:0], units_used[34:32], zero fill[39:35].
  output logic [u8xd_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import u8xd_pkg::*;

  acc_t   acc_q, acc_d;
  count_t remain_q, remain_d;
  count_t seq_len_q, seq_len_d;
  logic   out_valid_q;
  code_t  out_code_q, out_code_d;
  count_t out_units_q, out_units_d;
  logic   emit;
  logic   in_fire;
  unit_t  unit_byte;
  count_t lead_len;
  acc_t   acc_shift;

  assign unit_byte       = s_axis_tdata_i[UnitW-1:0];
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign lead_len        = lead_length(unit_byte);
  assign acc_shift       = {acc_q[AccW-PayloadW-1:0], unit_byte[PayloadW-1:0]};

  // Next sequence state and the result word that this byte produces.
  always_comb begin
    acc_d       = acc_q;
    remain_d    = remain_q;
    seq_len_d   = seq_len_q;
    emit        = 1'b0;
    out_code_d  = {1'b0, acc_shift};
    out_units_d = seq_len_q;
    if (remain_q != '0) begin
      // Continuation byte: taken without any check.
      acc_d    = acc_shift;
      remain_d = remain_q - 3'd1;
      emit     = (remain_q == 3'd1);
    end else if (lead_len != LenSingle) begin
      acc_d     = lead_payload(unit_byte, lead_len);
      seq_len_d = lead_len;
      remain_d  = lead_len - 3'd1;
    end else begin
      seq_len_d   = LenSingle;
      emit        = 1'b1;
      out_units_d = LenSingle;
      if (unit_byte == ByteFe) begin
        out_code_d = CodeFe;
      end else if (unit_byte == ByteFf) begin
        out_code_d = CodeFf;
      end else begin
        out_code_d = {24'd0, unit_byte};
      end
    end
  end

  // Sequence state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      remain_q  <= '0;
      seq_len_q <= '0;
    end else if (in_fire) begin
      acc_q     <= acc_d;
      remain_q  <= remain_d;
      seq_len_q <= seq_len_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= in_fire && emit;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_code_q  <= out_code_d;
      out_units_q <= out_units_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_units_q, out_code_q};

`ifndef SYNTHESIS
  // A presented word always reports a length from one to six.
  a_units_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_units_q != '0) && (out_units_q <= LenMax))
    else $error("units_used out of range");

  // While a sequence is open, the bytes still expected are fewer than its length.
  a_remain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (remain_q != '0) |-> (remain_q < seq_len_q) && (seq_len_q <= LenMax))
    else $error("sequence counters inconsistent");

  // The last byte of a sequence yields a word carrying that sequence's length.
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && remain_q == 3'd1) |=> out_valid_q && (out_units_q == $past(seq_len_q)))
    else $error("completed sequence not presented");

  // A byte that leaves a sequence open produces no word.
  a_mid_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && remain_d != '0) |=> !out_valid_q)
    else $error("word presented mid-sequence");
`endif

endmodule
